### rtl/esl_pkg.sv
// ============================================================================
// esl_pkg: shared types and constants for the grammar symbol lexer
// Holds the result item layout, result kinds, error codes, character classes,
// input operations, lexer mode codes and the result queue depth.
// ============================================================================
package esl_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_SYMBOL   = 3'd0;
    localparam logic [2:0] KIND_STR_CHAR = 3'd1;
    localparam logic [2:0] KIND_STR_END  = 3'd2;
    localparam logic [2:0] KIND_ERROR    = 3'd3;
    localparam logic [2:0] KIND_END_RUN  = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_STRAY_CLOSE   = 3'd1;
    localparam logic [2:0] ERR_OPEN_COMMENT  = 3'd2;
    localparam logic [2:0] ERR_BAD_STR_CHAR  = 3'd3;
    localparam logic [2:0] ERR_INVALID_SYM   = 3'd4;

    // Character classes with a special meaning.
    localparam logic [4:0] CLS_COMMENT_CLOSE = 5'd5;
    localparam logic [4:0] CLS_QUOTE_A       = 5'd10;
    localparam logic [4:0] CLS_QUOTE_B       = 5'd12;
    localparam logic [4:0] CLS_COMMENT_OPEN  = 5'd14;
    localparam logic [4:0] CLS_LAST_TERMINAL = 5'd19;
    localparam logic [4:0] CLS_SPACE         = 5'd20;
    localparam logic [4:0] CLS_LAST_GAP      = 5'd24;

    // Input operations.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // Lexer modes; the unused code behaves as error skip.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;

    // Result queue depth; room for two results is needed to take an item.
    localparam int RQ_DEPTH = 4;

    // One result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] symbol_type;
        logic [7:0] char_value;
        logic [2:0] error_code;
        logic       last_of_run;
    } t_result;

endpackage

### rtl/ebnf_symbol_lexer.sv
// ============================================================================
// ebnf_symbol_lexer: streaming lexer for grammar notation
// Turns classified characters into single symbols, string characters, string
// ends, errors and end-of-run marks, with comment and string tracking.
// ============================================================================
//
//  Channel   Handshake            Payload
//  input     i_valid / o_ready    i_op, i_char_class, i_char_code
//  output    o_valid / i_ready    o_kind, o_symbol_type, o_char_value,
//                                 o_error_code, o_last_of_run
//
// One item per cycle is accepted while o_ready is high; its results enter the
// result queue at the same edge and reach the outputs in queue order.
// An item yields zero, one or two results; the output delivers one per cycle
// while i_ready is high, so two-result items are limited by the output port.
// o_ready is high while the result queue has room for two results.
// Reset is synchronous and active low; it returns the lexer to normal mode
// and empties the result queue.
//
module ebnf_symbol_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [4:0] i_char_class,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_kind,
    output logic [4:0] o_symbol_type,
    output logic [7:0] o_char_value,
    output logic [2:0] o_error_code,
    output logic       o_last_of_run
);
    import esl_pkg::*;

    logic [1:0] r_mode, n_mode;
    logic       r_in_comment, n_in_comment;
    logic       r_open_quote, n_open_quote;

    logic       accept;
    logic       skip;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;
    t_result    res0, res1, head;
    logic       room2;
    logic [4:0] close_cls;

    assign accept    = i_valid && o_ready;
    assign skip      = (r_mode != MODE_NORMAL) && (r_mode != MODE_STRING);
    assign close_cls = r_open_quote ? CLS_QUOTE_B : CLS_QUOTE_A;

    // Next state and results for the item at the input ports.
    always_comb begin
        n_mode       = r_mode;
        n_in_comment = r_in_comment;
        n_open_quote = r_open_quote;
        res_cnt      = 2'd0;
        res0         = '0;
        res1         = '0;

        if (i_op == OP_EOS) begin
            // End of source: optional closing result, then end of run.
            n_mode       = MODE_NORMAL;
            n_in_comment = 1'b0;
            n_open_quote = 1'b0;
            res1.kind        = KIND_END_RUN;
            res1.last_of_run = 1'b1;
            if (!skip && r_in_comment) begin
                res0.kind       = KIND_ERROR;
                res0.error_code = ERR_OPEN_COMMENT;
                res_cnt         = 2'd2;
            end else if (!skip && r_mode == MODE_STRING) begin
                res0.kind = KIND_STR_END;
                res_cnt   = 2'd2;
            end else begin
                res0    = res1;
                res_cnt = 2'd1;
            end
        end else if (skip) begin
            // Error skip: characters are dropped until end of source.
        end else if (r_in_comment) begin
            if (i_char_class == CLS_COMMENT_CLOSE) begin
                n_in_comment = 1'b0;
            end
        end else if (i_char_class == CLS_COMMENT_OPEN) begin
            n_in_comment = 1'b1;
        end else if (i_char_class == CLS_COMMENT_CLOSE) begin
            n_mode           = MODE_SKIP;
            n_open_quote     = 1'b0;
            res0.kind        = KIND_ERROR;
            res0.error_code  = ERR_STRAY_CLOSE;
            res0.last_of_run = 1'b1;
            res_cnt          = 2'd1;
        end else if (r_mode == MODE_STRING) begin
            res0.last_of_run = 1'b1;
            res_cnt          = 2'd1;
            if (i_char_class == close_cls) begin
                n_mode       = MODE_NORMAL;
                n_open_quote = 1'b0;
                res0.kind    = KIND_STR_END;
            end else if (i_char_class <= CLS_LAST_TERMINAL
                         || i_char_class == CLS_SPACE) begin
                res0.kind       = KIND_STR_CHAR;
                res0.char_value = i_char_code;
            end else begin
                n_mode          = MODE_SKIP;
                n_open_quote    = 1'b0;
                res0.kind       = KIND_ERROR;
                res0.error_code = ERR_BAD_STR_CHAR;
            end
        end else if (i_char_class == CLS_QUOTE_A || i_char_class == CLS_QUOTE_B) begin
            n_mode       = MODE_STRING;
            n_open_quote = (i_char_class == CLS_QUOTE_B);
        end else if (i_char_class <= CLS_LAST_TERMINAL) begin
            res0.kind        = KIND_SYMBOL;
            res0.symbol_type = i_char_class;
            res0.char_value  = i_char_code;
            res0.last_of_run = 1'b1;
            res_cnt          = 2'd1;
        end else if (i_char_class <= CLS_LAST_GAP) begin
            // Gap characters are dropped outside strings.
        end else begin
            n_mode           = MODE_SKIP;
            res0.kind        = KIND_ERROR;
            res0.error_code  = ERR_INVALID_SYM;
            res0.last_of_run = 1'b1;
            res_cnt          = 2'd1;
        end
    end

    assign push_cnt = accept ? res_cnt : 2'd0;

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_in_comment <= 1'b0;
            r_open_quote <= 1'b0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_in_comment <= n_in_comment;
            r_open_quote <= n_open_quote;
        end
    end

    // Result queue between the lexer and the output port.
    esl_result_fifo u_result_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_item0    (res0),
        .i_item1    (res1),
        .i_pop      (i_ready),
        .o_valid    (o_valid),
        .o_item     (head),
        .o_room2    (room2)
    );

    assign o_ready       = room2;
    assign o_kind        = head.kind;
    assign o_symbol_type = head.symbol_type;
    assign o_char_value  = head.char_value;
    assign o_error_code  = head.error_code;
    assign o_last_of_run = head.last_of_run;

endmodule

### rtl/esl_result_fifo.sv
// ============================================================================
// esl_result_fifo: small result queue for the grammar symbol lexer
// Takes zero, one or two result items per cycle and hands out one per cycle
// while i_pop is high. Reports when there is room for a full pair of results.
// ============================================================================
module esl_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  esl_pkg::t_result i_item0,
    input  esl_pkg::t_result i_item1,
    input  logic             i_pop,
    output logic             o_valid,
    output esl_pkg::t_result o_item,
    output logic             o_room2
);
    import esl_pkg::*;

    localparam int PW = $clog2(RQ_DEPTH);
    localparam int CW = $clog2(RQ_DEPTH + 1);

    t_result         r_mem [RQ_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            pop_ok;
    logic [PW-1:0]   wr_ptr1;

    assign pop_ok  = i_pop && (r_count != '0);
    assign wr_ptr1 = r_wr_ptr + PW'(1);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= CW'(RQ_DEPTH - 2));

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + PW'(pop_ok);
        n_count  = r_count + CW'(i_push_cnt) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage: the first result goes to the write pointer, the second after it.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_item0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_item1;
        end
    end

endmodule
